[hw/rtl/ipidl_pkg.sv]
// Shared types, register indexes and widths for the limited incremental PID block.
package ipidl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W   = GAIN_W + SAMPLE_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int CHG_W    = ACC_W - FRAC_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_CURRENT         = 3'd0,
        REG_GAIN_PREVIOUS        = 3'd1,
        REG_GAIN_SECOND_PREVIOUS = 3'd2,
        REG_STEP_LIMIT_UP        = 3'd3,
        REG_STEP_LIMIT_DOWN      = 3'd4,
        REG_OUTPUT_MAX           = 3'd5,
        REG_OUTPUT_MIN           = 3'd6
    } t_reg_idx;

    typedef enum logic {
        CMD_PROCESS = 1'b0,
        CMD_CLEAR   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_current;
        logic [GAIN_W-1:0]   gain_previous;
        logic [GAIN_W-1:0]   gain_second_previous;
        logic [SAMPLE_W-1:0] step_limit_up;
        logic [SAMPLE_W-1:0] step_limit_down;
        logic [SAMPLE_W-1:0] output_max;
        logic [SAMPLE_W-1:0] output_min;
    } t_cfg;

    localparam logic [SAMPLE_W-1:0] POS_FULL = 16'h7fff;
    localparam logic [SAMPLE_W-1:0] NEG_FULL = 16'h8000;

endpackage

[hw/rtl/ipidl_cfg_regs.sv]
// Configuration register file: gains, step limits and output limits.
module ipidl_cfg_regs
    import ipidl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_GAIN_CURRENT:         n_cfg.gain_current         = i_cfg_data;
                REG_GAIN_PREVIOUS:        n_cfg.gain_previous        = i_cfg_data;
                REG_GAIN_SECOND_PREVIOUS: n_cfg.gain_second_previous = i_cfg_data;
                REG_STEP_LIMIT_UP:        n_cfg.step_limit_up   = i_cfg_data[SAMPLE_W-1:0];
                REG_STEP_LIMIT_DOWN:      n_cfg.step_limit_down = i_cfg_data[SAMPLE_W-1:0];
                REG_OUTPUT_MAX:           n_cfg.output_max      = i_cfg_data[SAMPLE_W-1:0];
                REG_OUTPUT_MIN:           n_cfg.output_min      = i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_current         <= '0;
            r_cfg.gain_previous        <= '0;
            r_cfg.gain_second_previous <= '0;
            r_cfg.step_limit_up        <= POS_FULL;
            r_cfg.step_limit_down      <= NEG_FULL;
            r_cfg.output_max           <= POS_FULL;
            r_cfg.output_min           <= NEG_FULL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ipidl_law.sv]
// Control law: three products, truncating scale, step clamp, sum and output clamp.
module ipidl_law
    import ipidl_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic [SAMPLE_W-1:0]  i_prev_sample,
    input  logic [SAMPLE_W-1:0]  i_older_sample,
    input  logic [SAMPLE_W-1:0]  i_prev_drive,
    output logic [SAMPLE_W-1:0]  o_drive
);

    logic signed [PROD_W-1:0]   p_cur;
    logic signed [PROD_W-1:0]   p_prev;
    logic signed [PROD_W-1:0]   p_older;
    logic signed [ACC_W-1:0]    acc;
    logic                       round_up;
    logic signed [CHG_W-1:0]    change;
    logic signed [CHG_W-1:0]    lim_up;
    logic signed [CHG_W-1:0]    lim_dn;
    logic signed [CHG_W-1:0]    chg_hi;
    logic signed [CHG_W-1:0]    chg_cl;
    logic signed [SAMPLE_W:0]   y_sum;
    logic signed [SAMPLE_W:0]   y_max;
    logic signed [SAMPLE_W:0]   y_min;
    logic signed [SAMPLE_W:0]   y_hi;
    logic signed [SAMPLE_W:0]   y_cl;

    // 32x16 signed products, full 48-bit result
    assign p_cur   = $signed(i_cfg.gain_current) * $signed(i_sample);
    assign p_prev  = $signed(i_cfg.gain_previous) * $signed(i_prev_sample);
    assign p_older = $signed(i_cfg.gain_second_previous) * $signed(i_older_sample);

    assign acc = $signed({{2{p_cur[PROD_W-1]}}, p_cur})
               + $signed({{2{p_prev[PROD_W-1]}}, p_prev})
               + $signed({{2{p_older[PROD_W-1]}}, p_older});

    // arithmetic shift floors; bump negatives with a fraction to truncate toward zero
    assign round_up = acc[ACC_W-1] & (|acc[FRAC_W-1:0]);
    assign change   = $signed(acc[ACC_W-1:FRAC_W] + {{(CHG_W-1){1'b0}}, round_up});

    assign lim_up = $signed({{(CHG_W-SAMPLE_W){i_cfg.step_limit_up[SAMPLE_W-1]}},
                             i_cfg.step_limit_up});
    assign lim_dn = $signed({{(CHG_W-SAMPLE_W){i_cfg.step_limit_down[SAMPLE_W-1]}},
                             i_cfg.step_limit_down});

    // upper limit first, lower second: lower wins when limits cross
    assign chg_hi = (change >= lim_up) ? lim_up : change;
    assign chg_cl = (chg_hi <= lim_dn) ? lim_dn : chg_hi;

    assign y_sum = $signed({chg_cl[SAMPLE_W-1], chg_cl[SAMPLE_W-1:0]})
                 + $signed({i_prev_drive[SAMPLE_W-1], i_prev_drive});
    assign y_max = $signed({i_cfg.output_max[SAMPLE_W-1], i_cfg.output_max});
    assign y_min = $signed({i_cfg.output_min[SAMPLE_W-1], i_cfg.output_min});
    assign y_hi  = (y_sum >= y_max) ? y_max : y_sum;
    assign y_cl  = (y_hi <= y_min) ? y_min : y_hi;

    assign o_drive = y_cl[SAMPLE_W-1:0];

endmodule

[hw/rtl/incremental_pid_limited_top.sv]
// Top level of the limited incremental PID controller: handshake, history and result register.
//
// Velocity-form PID with step and output clamps. Each word on the input channel
// (command, 16-bit signed error sample) yields one 16-bit drive word on the output
// channel. An accepted word sits in the input register, passes through the combinational
// control law and lands in the result register, so the block sustains one word per cycle
// while the output is ready; o_out_valid rises as the word is written into the result
// register, which waits while a held result is stalled on the output. The
// history (two past samples, last drive) is updated as each word moves into the
// result register, which keeps back-to-back words exact. Configuration writes take
// effect on the next cycle and are meant to be made while no word is in flight.
module incremental_pid_limited_top
    import ipidl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_drive,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                 cfg;
    logic                 r_in_valid;
    t_cmd                 r_in_cmd;
    logic [SAMPLE_W-1:0]  r_in_sample;
    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_drive;
    logic [SAMPLE_W-1:0]  r_prev_sample;
    logic [SAMPLE_W-1:0]  r_older_sample;
    logic [SAMPLE_W-1:0]  n_drive;
    logic [SAMPLE_W-1:0]  law_drive;
    logic                 advance;
    logic                 in_accept;

    ipidl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // the result register always holds the last drive, so it doubles as y[n-1]
    ipidl_law u_law (
        .i_cfg          (cfg),
        .i_sample       (r_in_sample),
        .i_prev_sample  (r_prev_sample),
        .i_older_sample (r_older_sample),
        .i_prev_drive   (r_drive),
        .o_drive        (law_drive)
    );

    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;
    assign in_accept  = i_in_valid & o_in_ready;
    assign n_drive    = (r_in_cmd == CMD_CLEAR) ? '0 : law_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd    <= t_cmd'(i_cmd);
            r_in_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_drive        <= '0;
            r_prev_sample  <= '0;
            r_older_sample <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_drive     <= n_drive;
                if (r_in_cmd == CMD_CLEAR) begin
                    r_prev_sample  <= '0;
                    r_older_sample <= '0;
                end else begin
                    r_prev_sample  <= r_in_sample;
                    r_older_sample <= r_prev_sample;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == CMD_CLEAR |=>
            r_out_valid && r_drive == '0 && r_prev_sample == '0 && r_older_sample == '0)
        else $error("clear word did not zero drive and history");

    a_history_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == CMD_PROCESS |=>
            r_older_sample == $past(r_prev_sample) && r_prev_sample == $past(r_in_sample))
        else $error("sample history did not shift");

    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_cmd == CMD_PROCESS |=>
            $signed(r_drive) <= $signed(cfg.output_max) || r_drive == cfg.output_min)
        else $error("drive above output limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_drive))
        else $error("stalled result lost or overwritten");

endmodule
